/* design/usb_boot_keyboard_descriptor_scan_assert.svh */
// ----------------------------------------------------------------------------
// Boot keyboard descriptor scan: assertion macros
// Small wrappers for the concurrent checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef USB_BOOT_KEYBOARD_DESCRIPTOR_SCAN_ASSERT_SVH
`define USB_BOOT_KEYBOARD_DESCRIPTOR_SCAN_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define UBKD_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ubkd check failed: same-cycle rule");

// Next-cycle implication, sampled on clk, off during reset.
`define UBKD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ubkd check failed: next-cycle rule");

`endif

/* design/ubkd_pkg.sv */
// ----------------------------------------------------------------------------
// ubkd_pkg
// Word types and descriptor constants for the boot keyboard descriptor scan.
// ----------------------------------------------------------------------------
package ubkd_pkg;

    // incoming descriptor byte
    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } in_word_t;

    // scan result, given once per descriptor set
    typedef struct packed {
        logic       found;
        logic [7:0] interface_id;
        logic [3:0] endpoint_id;
        logic [6:0] packet_limit;
        logic [7:0] poll_interval;
    } out_word_t;

    localparam logic [7:0]  KIND_INTERFACE    = 8'd4;
    localparam logic [7:0]  KIND_ENDPOINT     = 8'd5;
    localparam logic [7:0]  INTERFACE_MIN_LEN = 8'd9;
    localparam logic [7:0]  ENDPOINT_MIN_LEN  = 8'd7;
    localparam logic [7:0]  DESC_MIN_LEN      = 8'd2;
    localparam logic [7:0]  DIR_IN_BIT        = 8'h80;
    localparam logic [7:0]  EP_NUM_MASK       = 8'h0f;
    localparam logic [1:0]  XFER_INTERRUPT    = 2'd3;
    localparam logic [7:0]  HID_CLASS         = 8'd3;
    localparam logic [7:0]  BOOT_SUBCLASS     = 8'd1;
    localparam logic [7:0]  KEYBOARD_PROTO    = 8'd1;
    localparam logic [15:0] PACKET_MIN        = 16'd8;
    localparam logic [15:0] PACKET_MAX        = 16'd64;

    // byte offsets inside a descriptor
    localparam logic [7:0] POS_LEN      = 8'd0;
    localparam logic [7:0] POS_KIND     = 8'd1;
    localparam logic [7:0] POS_IF_NUM   = 8'd2;
    localparam logic [7:0] POS_IF_ALT   = 8'd3;
    localparam logic [7:0] POS_IF_CLASS = 8'd5;
    localparam logic [7:0] POS_IF_SUB   = 8'd6;
    localparam logic [7:0] POS_IF_PROTO = 8'd7;
    localparam logic [7:0] POS_EP_ADDR  = 8'd2;
    localparam logic [7:0] POS_EP_ATTR  = 8'd3;
    localparam logic [7:0] POS_EP_PKT_L = 8'd4;
    localparam logic [7:0] POS_EP_PKT_H = 8'd5;
    localparam logic [7:0] POS_EP_INTV  = 8'd6;

endpackage

/* design/ubkd_in_stage.sv */
// ----------------------------------------------------------------------------
// ubkd_in_stage
// Input register: holds one descriptor byte until the scan core takes it.
// ----------------------------------------------------------------------------
module ubkd_in_stage (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               desc_valid,
    output logic               desc_stall,
    input  ubkd_pkg::in_word_t desc_word,
    input  logic               advance,
    output logic               hold_valid,
    output ubkd_pkg::in_word_t hold_word
);
    import ubkd_pkg::*;

    logic     hold_valid_reg;
    logic     hold_valid_next;
    in_word_t hold_word_reg;
    logic     load;

    // busy only while the held word cannot move on
    assign desc_stall = hold_valid_reg && !advance;
    assign load       = desc_valid && !desc_stall;

    always_comb
    begin
        hold_valid_next = hold_valid_reg;
        if (load)
        begin
            hold_valid_next = 1'b1;
        end
        else if (advance)
        begin
            hold_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
        end
        else
        begin
            hold_valid_reg <= hold_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            hold_word_reg <= desc_word;
        end
    end

    assign hold_valid = hold_valid_reg;
    assign hold_word  = hold_word_reg;

endmodule

/* design/ubkd_scan_core.sv */
// ----------------------------------------------------------------------------
// ubkd_scan_core
// Per-byte descriptor walk; builds the result on the final byte.
// ----------------------------------------------------------------------------
module ubkd_scan_core (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                take,
    input  ubkd_pkg::in_word_t  word,
    output logic                res_load,
    output ubkd_pkg::out_word_t res_word
);
    import ubkd_pkg::*;

    logic [7:0]  pos_reg,     pos_next;
    logic [7:0]  len_reg,     len_next;
    logic [7:0]  kind_reg,    kind_next;
    logic        match_reg,   match_next;
    logic        cand_reg,    cand_next;
    logic [7:0]  held_if_reg, held_if_next;
    logic [7:0]  pend_if_reg, pend_if_next;
    logic [3:0]  ep_reg,      ep_next;
    logic [15:0] pkt_reg,     pkt_next;
    logic [7:0]  intv_reg,    intv_next;
    logic        decided_reg, decided_next;
    logic        found_reg,   found_next;
    logic        end_now;
    logic        ok;
    logic [7:0]  b;

    assign b = word.data_byte;

    always_comb
    begin
        pos_next     = pos_reg;
        len_next     = len_reg;
        kind_next    = kind_reg;
        match_next   = match_reg;
        cand_next    = cand_reg;
        held_if_next = held_if_reg;
        pend_if_next = pend_if_reg;
        ep_next      = ep_reg;
        pkt_next     = pkt_reg;
        intv_next    = intv_reg;
        decided_next = decided_reg;
        found_next   = found_reg;
        end_now      = 1'b0;

        if (!decided_reg)
        begin
            if (pos_reg == POS_LEN)
            begin
                len_next = b;
                if (b < DESC_MIN_LEN)
                begin
                    // short descriptor: give up at once
                    decided_next = 1'b1;
                    found_next   = 1'b0;
                end
                else
                begin
                    match_next = 1'b1;
                    pos_next   = POS_KIND;
                end
            end
            else
            begin
                if (pos_reg == POS_KIND)
                begin
                    kind_next = b;
                end
                else if (kind_reg == KIND_INTERFACE)
                begin
                    if (pos_reg == POS_IF_NUM)
                    begin
                        pend_if_next = b;
                    end
                    else if (pos_reg == POS_IF_ALT)
                    begin
                        if (b != 8'd0) match_next = 1'b0;
                    end
                    else if (pos_reg == POS_IF_CLASS)
                    begin
                        if (b != HID_CLASS) match_next = 1'b0;
                    end
                    else if (pos_reg == POS_IF_SUB)
                    begin
                        if (b != BOOT_SUBCLASS) match_next = 1'b0;
                    end
                    else if (pos_reg == POS_IF_PROTO)
                    begin
                        if (b != KEYBOARD_PROTO) match_next = 1'b0;
                    end
                end
                else if (kind_reg == KIND_ENDPOINT)
                begin
                    if (pos_reg == POS_EP_ADDR)
                    begin
                        ep_next = b[3:0] & EP_NUM_MASK[3:0];
                        if ((b & DIR_IN_BIT) == 8'd0) match_next = 1'b0;
                    end
                    else if (pos_reg == POS_EP_ATTR)
                    begin
                        if (b[1:0] != XFER_INTERRUPT) match_next = 1'b0;
                    end
                    else if (pos_reg == POS_EP_PKT_L)
                    begin
                        pkt_next = {pkt_reg[15:8], b};
                    end
                    else if (pos_reg == POS_EP_PKT_H)
                    begin
                        pkt_next = {b, pkt_reg[7:0]};
                    end
                    else if (pos_reg == POS_EP_INTV)
                    begin
                        intv_next = b;
                    end
                end

                end_now = ({1'b0, pos_reg} + 9'd1) == {1'b0, len_reg};
                if (end_now)
                begin
                    pos_next = POS_LEN;
                    if (kind_next == KIND_INTERFACE && len_reg >= INTERFACE_MIN_LEN)
                    begin
                        cand_next = match_next;
                        if (match_next) held_if_next = pend_if_next;
                    end
                    else if (kind_next == KIND_ENDPOINT && len_reg >= ENDPOINT_MIN_LEN
                             && cand_reg && match_next)
                    begin
                        decided_next = 1'b1;
                        found_next   = (intv_next != 8'd0) && (pkt_next >= PACKET_MIN)
                                       && (pkt_next <= PACKET_MAX);
                    end
                end
                else
                begin
                    pos_next = pos_reg + 8'd1;
                end
            end
        end
    end

    // result reflects the state after this byte
    assign ok       = decided_next && found_next;
    assign res_load = take && word.last_byte;

    always_comb
    begin
        res_word               = '0;
        res_word.found         = ok;
        if (ok)
        begin
            res_word.interface_id  = held_if_next;
            res_word.endpoint_id   = ep_next;
            res_word.packet_limit  = pkt_next[6:0];
            res_word.poll_interval = intv_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg     <= '0;
            len_reg     <= '0;
            kind_reg    <= '0;
            match_reg   <= 1'b0;
            cand_reg    <= 1'b0;
            held_if_reg <= '0;
            pend_if_reg <= '0;
            ep_reg      <= '0;
            pkt_reg     <= '0;
            intv_reg    <= '0;
            decided_reg <= 1'b0;
            found_reg   <= 1'b0;
        end
        else if (take)
        begin
            if (word.last_byte)
            begin
                // final byte: start over for the next set
                pos_reg     <= '0;
                len_reg     <= '0;
                kind_reg    <= '0;
                match_reg   <= 1'b0;
                cand_reg    <= 1'b0;
                held_if_reg <= '0;
                pend_if_reg <= '0;
                ep_reg      <= '0;
                pkt_reg     <= '0;
                intv_reg    <= '0;
                decided_reg <= 1'b0;
                found_reg   <= 1'b0;
            end
            else
            begin
                pos_reg     <= pos_next;
                len_reg     <= len_next;
                kind_reg    <= kind_next;
                match_reg   <= match_next;
                cand_reg    <= cand_next;
                held_if_reg <= held_if_next;
                pend_if_reg <= pend_if_next;
                ep_reg      <= ep_next;
                pkt_reg     <= pkt_next;
                intv_reg    <= intv_next;
                decided_reg <= decided_next;
                found_reg   <= found_next;
            end
        end
    end

endmodule

/* design/ubkd_out_stage.sv */
// ----------------------------------------------------------------------------
// ubkd_out_stage
// Result register: holds the scan result until the consumer takes it.
// ----------------------------------------------------------------------------
module ubkd_out_stage (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                load,
    input  ubkd_pkg::out_word_t load_word,
    output logic                result_valid,
    input  logic                result_stall,
    output ubkd_pkg::out_word_t result_word
);
    import ubkd_pkg::*;

    logic      valid_reg;
    logic      valid_next;
    out_word_t word_reg;

    // load is only raised when the register is free or draining
    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (valid_reg && !result_stall)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            word_reg <= load_word;
        end
    end

    assign result_valid = valid_reg;
    assign result_word  = word_reg;

endmodule

/* design/usb_boot_keyboard_descriptor_scan.sv */
// The input register holds each byte; a final byte's result is then registered in the result register.
// Throughput: one descriptor byte per cycle; one result per descriptor set.
// The only back-pressure comes from a final byte meeting a stalled, full result register.
// Reset: rst_n (async, active low) clears the scan state and both valid flags.
// After each final byte the scan state returns to its reset values by itself.
// ----------------------------------------------------------------------------
// usb_boot_keyboard_descriptor_scan
// Walks a USB configuration descriptor set byte by byte and reports the first
// boot keyboard interrupt IN endpoint, with its interface and endpoint fields.
// ----------------------------------------------------------------------------
`include "usb_boot_keyboard_descriptor_scan_assert.svh"

module usb_boot_keyboard_descriptor_scan (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                desc_valid,
    output logic                desc_stall,
    input  ubkd_pkg::in_word_t  desc_word,
    output logic                result_valid,
    input  logic                result_stall,
    output ubkd_pkg::out_word_t result_word
);
    import ubkd_pkg::*;

    logic      hold_valid;
    in_word_t  hold_word;
    logic      advance;
    logic      take;
    logic      res_load;
    out_word_t res_word;
    logic      miss_fields_zero;
    logic      hit_fields_legal;
    logic      last_taken;

    // Held byte moves on unless it is a final byte and the result register
    // is full and stalled. Ordinary bytes never wait on the consumer.
    assign advance = !hold_word.last_byte || !result_valid || !result_stall;
    assign take    = hold_valid && advance;

    // Stage 1: input register.
    ubkd_in_stage u_in (
        .clk        (clk),
        .rst_n      (rst_n),
        .desc_valid (desc_valid),
        .desc_stall (desc_stall),
        .desc_word  (desc_word),
        .advance    (advance),
        .hold_valid (hold_valid),
        .hold_word  (hold_word)
    );

    // Descriptor walk state plus the result logic for the final byte.
    ubkd_scan_core u_core (
        .clk      (clk),
        .rst_n    (rst_n),
        .take     (take),
        .word     (hold_word),
        .res_load (res_load),
        .res_word (res_word)
    );

    // Stage 2: result register.
    ubkd_out_stage u_out (
        .clk          (clk),
        .rst_n        (rst_n),
        .load         (res_load),
        .load_word    (res_word),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result_word  (result_word)
    );

    // Checks.
    assign miss_fields_zero = result_word.interface_id == 8'd0
                              && result_word.endpoint_id == 4'd0
                              && result_word.packet_limit == 7'd0
                              && result_word.poll_interval == 8'd0;
    assign hit_fields_legal = result_word.packet_limit >= 7'd8
                              && result_word.packet_limit <= 7'd64
                              && result_word.poll_interval != 8'd0;
    assign last_taken       = hold_valid && hold_word.last_byte && advance;

    // A miss reports all value fields as zero.
    `UBKD_ASSERT_NOW(a_miss_zero, result_valid && !result_word.found, miss_fields_zero)
    // A hit carries a legal packet size and a nonzero interval.
    `UBKD_ASSERT_NOW(a_hit_legal, result_valid && result_word.found, hit_fields_legal)
    // A new result only follows a final byte taken from the input register.
    `UBKD_ASSERT_NOW(a_result_source, $rose(result_valid), $past(last_taken))
    // Loading never lands on a stalled, full result register.
    `UBKD_ASSERT_NOW(a_no_overwrite, result_valid && result_stall, !res_load)

endmodule
